// File: sv/tm_pkg.sv
// Package with shared constants for the triangle metrics block.
`default_nettype none
package tm_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int AREA_WIDTH      = 24;
endpackage
`default_nettype wire

// File: sv/tm_in_if.sv
// Input channel interface carrying the three vertices of one triangle.
`default_nettype none
interface tm_in_if #(parameter int CW = tm_pkg::COORD_WIDTH_DEF);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface
`default_nettype wire

// File: sv/tm_out_if.sv
// Output channel interface carrying the metrics of one triangle.
`default_nettype none
interface tm_out_if #(parameter int CW = tm_pkg::COORD_WIDTH_DEF);
    logic                            valid;
    logic                            ready;
    logic                            is_triangle;
    logic [CW+2:0]                   perimeter;
    logic [tm_pkg::AREA_WIDTH-1:0]   area;
    logic signed [CW-1:0]            centroid_x;
    logic signed [CW-1:0]            centroid_y;

    modport source (output valid, is_triangle, perimeter, area, centroid_x, centroid_y,
                    input ready);
    modport sink   (input valid, is_triangle, perimeter, area, centroid_x, centroid_y,
                     output ready);
endinterface
`default_nettype wire

// File: sv/tm_sqrt_cell.sv
// One cell of the square root row: produces one root bit per lane.
`default_nettype none
module tm_sqrt_cell #(
    parameter int LANES = 1,
    parameter int RW    = 4,
    parameter int SBW   = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [LANES-1:0][RW-1:0]            rad_in,
    input  logic [LANES-1:0][RW/2+1:0]          rem_in,
    input  logic [LANES-1:0][RW/2-1:0]          root_in,
    input  logic [SBW-1:0]                      sb_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [LANES-1:0][RW-1:0]            rad_out,
    output logic [LANES-1:0][RW/2+1:0]          rem_out,
    output logic [LANES-1:0][RW/2-1:0]          root_out,
    output logic [SBW-1:0]                      sb_out
);
    localparam int NW   = RW / 2;
    localparam int REMW = NW + 2;

    logic                          v_reg;
    logic [LANES-1:0][RW-1:0]      rad_reg,  rad_next;
    logic [LANES-1:0][REMW-1:0]    rem_reg,  rem_next;
    logic [LANES-1:0][NW-1:0]      root_reg, root_next;
    logic [SBW-1:0]                sb_reg;
    logic [LANES-1:0][REMW-1:0]    cur;
    logic [LANES-1:0][REMW-1:0]    trial;
    logic [LANES-1:0]              ge;

    assign in_ready = !v_reg || out_ready;

    // Restoring step: bring down two radicand bits and try the next root bit.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            cur[l]       = {rem_in[l][NW-1:0], rad_in[l][RW-1 -: 2]};
            trial[l]     = {root_in[l], 2'b01};
            ge[l]        = cur[l] >= trial[l];
            rem_next[l]  = ge[l] ? cur[l] - trial[l] : cur[l];
            root_next[l] = {root_in[l][NW-2:0], ge[l]};
            rad_next[l]  = {rad_in[l][RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sb_reg   <= sb_in;
        end
    end

    assign out_valid = v_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign sb_out    = sb_reg;
endmodule
`default_nettype wire

// File: sv/tm_sqrt_chain.sv
// Row of square root cells giving floor square roots of several radicands.
`default_nettype none
module tm_sqrt_chain #(
    parameter int LANES = 1,
    parameter int RW    = 4,
    parameter int SBW   = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][RW-1:0]      rad_in,
    input  logic [SBW-1:0]                sb_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LANES-1:0][RW/2-1:0]    root_out,
    output logic [SBW-1:0]                sb_out
);
    localparam int NW = RW / 2;

    logic [NW:0]                        v;
    logic [NW:0]                        r;
    logic [NW:0][LANES-1:0][RW-1:0]     rad;
    logic [NW:0][LANES-1:0][NW+1:0]     rem;
    logic [NW:0][LANES-1:0][NW-1:0]     root;
    logic [NW:0][SBW-1:0]               sb;

    assign v[0]    = in_valid;
    assign in_ready = r[0];
    assign rad[0]  = rad_in;
    assign rem[0]  = '0;
    assign root[0] = '0;
    assign sb[0]   = sb_in;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        tm_sqrt_cell #(.LANES(LANES), .RW(RW), .SBW(SBW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[i]),
            .in_ready (r[i]),
            .rad_in   (rad[i]),
            .rem_in   (rem[i]),
            .root_in  (root[i]),
            .sb_in    (sb[i]),
            .out_valid(v[i+1]),
            .out_ready(r[i+1]),
            .rad_out  (rad[i+1]),
            .rem_out  (rem[i+1]),
            .root_out (root[i+1]),
            .sb_out   (sb[i+1])
        );
    end

    assign r[NW]     = out_ready;
    assign out_valid = v[NW];
    assign root_out  = root[NW];
    assign sb_out    = sb[NW];
endmodule
`default_nettype wire

// File: sv/triangle_metrics.sv
// Top level of the triangle metrics pipeline: sides, perimeter, Heron area, centroid.
//
// The block accepts one triangle transaction per clock cycle while not stalled and returns
// one metrics transaction for each, in order. It has 3 front stages, COORD_WIDTH+1 cells
// of the side square root row, 4 stages that form Heron's product, 2*(COORD_WIDTH+3)
// cells of the area square root row and one output register.
// Every stage has its own valid bit and takes new data whenever it is empty or its
// successor takes its contents, so bubbles close up and the input keeps accepting while
// a finished result waits at the output. The side lengths are floor square roots of the
// squared vertex distances, the area is floor(sqrt(P(b+c-a)(a+c-b)(a+b-c))) shifted right
// by FRAC_BITS+2 and saturated, and it reads zero when the strict triangle inequality
// fails. The centroid is each coordinate sum divided by three, truncated toward zero.
`default_nettype none
module triangle_metrics #(
    parameter int COORD_WIDTH = tm_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tm_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tm_in_if.sink         vertices,
    tm_out_if.source      metrics
);
    import tm_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int SW    = CW + 1;          // side length width
    localparam int SRW   = 2 * SW;          // side radicand width
    localparam int PW    = CW + 3;          // perimeter and factor width
    localparam int ARW   = 4 * PW;          // area radicand width
    localparam int MW    = CW + 1;          // centroid sum magnitude width
    localparam int XW    = (2 * PW > AREA_WIDTH) ? 2 * PW : AREA_WIDTH;
    localparam longint unsigned RECIP_FULL = ((64'd1 << (MW + 1)) + 64'd2) / 64'd3;
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];
    localparam logic [AREA_WIDTH-1:0] AREA_MAX = {AREA_WIDTH{1'b1}};

    // Front stage 0: absolute coordinate differences and coordinate sums.
    logic                      f0_v_reg, f0_rdy;
    logic [2:0][CW-1:0]        f0_dx_reg, f0_dy_reg;
    logic signed [CW+1:0]      f0_sx_reg, f0_sy_reg;
    logic [2:0][CW-1:0]        dx_next, dy_next;

    // Front stage 1: squares and centroid reciprocal products.
    logic                      f1_v_reg, f1_rdy;
    logic [2:0][2*CW-1:0]      f1_qx_reg, f1_qy_reg;
    logic [2*MW-1:0]           f1_px_reg, f1_py_reg;
    logic                      f1_nx_reg, f1_ny_reg;
    logic [MW-1:0]             mag_x, mag_y;

    // Front stage 2: side radicands and centroid.
    logic                      f2_v_reg, f2_rdy;
    logic [2:0][SRW-1:0]       f2_rad_reg;
    logic [CW-1:0]             f2_gx_reg, f2_gy_reg;
    logic                      sc_in_rdy_w;

    logic                      sc_out_v;
    logic [2:0][SW-1:0]        sc_root;
    logic [2*CW-1:0]           sc_sb;

    // Heron stages.
    logic                      m0_v_reg, m0_rdy;
    logic                      m0_ok_reg;
    logic [PW-1:0]             m0_per_reg, m0_f1_reg, m0_f2_reg, m0_f3_reg;
    logic [2*CW-1:0]           m0_sb_reg;
    logic                      m1_v_reg, m1_rdy;
    logic [2*PW-1:0]           m1_p1_reg, m1_p2_reg;
    logic [PW:0]               m1_sb_hd_reg;
    logic [2*CW-1:0]           m1_sb_reg;
    logic                      m2_v_reg, m2_rdy;
    logic [2*PW-1:0]           m2_hh_reg, m2_hl_reg, m2_lh_reg, m2_ll_reg;
    logic [PW:0]               m2_sb_hd_reg;
    logic [2*CW-1:0]           m2_sb_reg;
    logic                      m3_v_reg, m3_rdy;
    logic [0:0][ARW-1:0]       m3_prod_reg;
    logic [PW+2*CW:0]          m3_sb_reg;

    logic                      ac_out_v;
    logic [0:0][2*PW-1:0]      ac_root;
    logic [PW+2*CW:0]          ac_sb;
    logic                      ac_in_rdy;

    // Output register.
    logic                      o_v_reg, o_rdy;
    logic                      o_ok_reg;
    logic [PW-1:0]             o_per_reg;
    logic [AREA_WIDTH-1:0]     o_area_reg, area_next;
    logic [CW-1:0]             o_gx_reg, o_gy_reg;
    logic [XW-1:0]             area_ext;

    logic [2:0][SW-1:0]        s_ext;
    logic [PW-1:0]             sa, sb, sc;

    // ---------------- front stage 0 ----------------
    function automatic logic [CW-1:0] absdiff(input logic signed [CW-1:0] p,
                                              input logic signed [CW-1:0] q);
        logic signed [CW:0] d;
        d = {p[CW-1], p} - {q[CW-1], q};
        absdiff = d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    assign dx_next[0] = absdiff(vertices.ax, vertices.bx);
    assign dy_next[0] = absdiff(vertices.ay, vertices.by_coord);
    assign dx_next[1] = absdiff(vertices.bx, vertices.cx);
    assign dy_next[1] = absdiff(vertices.by_coord, vertices.cy);
    assign dx_next[2] = absdiff(vertices.cx, vertices.ax);
    assign dy_next[2] = absdiff(vertices.cy, vertices.ay);

    assign f0_rdy = !f0_v_reg || f1_rdy;
    assign vertices.ready = f0_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f0_v_reg <= 1'b0;
        else if (f0_rdy)
            f0_v_reg <= vertices.valid;
    end

    always_ff @(posedge clk)
    begin
        if (f0_rdy && vertices.valid)
        begin
            f0_dx_reg <= dx_next;
            f0_dy_reg <= dy_next;
            f0_sx_reg <= (CW+2)'(vertices.ax) + (CW+2)'(vertices.bx) + (CW+2)'(vertices.cx);
            f0_sy_reg <= (CW+2)'(vertices.ay) + (CW+2)'(vertices.by_coord)
                         + (CW+2)'(vertices.cy);
        end
    end

    // ---------------- front stage 1 ----------------
    // Division by three multiplies the sum magnitude by a rounded-up reciprocal of three.
    // The magnitudes are held unsigned so that they widen with zeros.
    assign mag_x = f0_sx_reg[CW+1] ? MW'(-f0_sx_reg) : MW'(f0_sx_reg);
    assign mag_y = f0_sy_reg[CW+1] ? MW'(-f0_sy_reg) : MW'(f0_sy_reg);

    assign f1_rdy = !f1_v_reg || f2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_v_reg <= 1'b0;
        else if (f1_rdy)
            f1_v_reg <= f0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (f1_rdy && f0_v_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f1_qx_reg[i] <= (2*CW)'(f0_dx_reg[i]) * (2*CW)'(f0_dx_reg[i]);
                f1_qy_reg[i] <= (2*CW)'(f0_dy_reg[i]) * (2*CW)'(f0_dy_reg[i]);
            end
            f1_nx_reg <= f0_sx_reg[CW+1];
            f1_ny_reg <= f0_sy_reg[CW+1];
            f1_px_reg <= (2*MW)'(mag_x) * (2*MW)'(RECIP);
            f1_py_reg <= (2*MW)'(mag_y) * (2*MW)'(RECIP);
        end
    end

    // ---------------- front stage 2 ----------------
    assign f2_rdy = !f2_v_reg || sc_in_rdy_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_v_reg <= 1'b0;
        else if (f2_rdy)
            f2_v_reg <= f1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (f2_rdy && f1_v_reg)
        begin
            for (int i = 0; i < 3; i++)
                f2_rad_reg[i] <= SRW'(f1_qx_reg[i]) + SRW'(f1_qy_reg[i]);
            f2_gx_reg <= f1_nx_reg ? CW'(-f1_px_reg[2*MW-1:MW+1]) : f1_px_reg[2*MW-1:MW+1];
            f2_gy_reg <= f1_ny_reg ? CW'(-f1_py_reg[2*MW-1:MW+1]) : f1_py_reg[2*MW-1:MW+1];
        end
    end

    // Side lengths a = |AB|, b = |BC|, c = |CA| in three lanes of one row.
    tm_sqrt_chain #(.LANES(3), .RW(SRW), .SBW(2*CW)) u_side_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (f2_v_reg),
        .in_ready (sc_in_rdy_w),
        .rad_in   (f2_rad_reg),
        .sb_in    ({f2_gx_reg, f2_gy_reg}),
        .out_valid(sc_out_v),
        .out_ready(m0_rdy),
        .root_out (sc_root),
        .sb_out   (sc_sb)
    );

    // ---------------- Heron stage 0: perimeter, validity, factors ----------------
    assign s_ext = sc_root;
    assign sa = PW'(s_ext[0]);
    assign sb = PW'(s_ext[1]);
    assign sc = PW'(s_ext[2]);

    assign m0_rdy = !m0_v_reg || m1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m0_v_reg <= 1'b0;
        else if (m0_rdy)
            m0_v_reg <= sc_out_v;
    end

    always_ff @(posedge clk)
    begin
        if (m0_rdy && sc_out_v)
        begin
            m0_per_reg <= sa + sb + sc;
            m0_ok_reg  <= (sa + sb > sc) && (sb + sc > sa) && (sa + sc > sb);
            m0_f1_reg  <= sb + sc - sa;
            m0_f2_reg  <= sa + sc - sb;
            m0_f3_reg  <= sa + sb - sc;
            m0_sb_reg  <= sc_sb;
        end
    end

    // ---------------- Heron stage 1: two factor products ----------------
    assign m1_rdy = !m1_v_reg || m2_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= 1'b0;
        else if (m1_rdy)
            m1_v_reg <= m0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (m1_rdy && m0_v_reg)
        begin
            m1_p1_reg    <= (2*PW)'(m0_per_reg) * (2*PW)'(m0_f1_reg);
            m1_p2_reg    <= (2*PW)'(m0_f2_reg) * (2*PW)'(m0_f3_reg);
            m1_sb_hd_reg <= {m0_ok_reg, m0_per_reg};
            m1_sb_reg    <= m0_sb_reg;
        end
    end

    // ---------------- Heron stage 2: partial products of the wide multiply ----------------
    assign m2_rdy = !m2_v_reg || m3_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_v_reg <= 1'b0;
        else if (m2_rdy)
            m2_v_reg <= m1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (m2_rdy && m1_v_reg)
        begin
            m2_hh_reg    <= (2*PW)'(m1_p1_reg[2*PW-1:PW]) * (2*PW)'(m1_p2_reg[2*PW-1:PW]);
            m2_hl_reg    <= (2*PW)'(m1_p1_reg[2*PW-1:PW]) * (2*PW)'(m1_p2_reg[PW-1:0]);
            m2_lh_reg    <= (2*PW)'(m1_p1_reg[PW-1:0]) * (2*PW)'(m1_p2_reg[2*PW-1:PW]);
            m2_ll_reg    <= (2*PW)'(m1_p1_reg[PW-1:0]) * (2*PW)'(m1_p2_reg[PW-1:0]);
            m2_sb_hd_reg <= m1_sb_hd_reg;
            m2_sb_reg    <= m1_sb_reg;
        end
    end

    // ---------------- Heron stage 3: sum of partial products ----------------
    assign m3_rdy = !m3_v_reg || ac_in_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_v_reg <= 1'b0;
        else if (m3_rdy)
            m3_v_reg <= m2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (m3_rdy && m2_v_reg)
        begin
            m3_prod_reg[0] <= {m2_hh_reg, m2_ll_reg}
                              + (ARW'(m2_hl_reg) << PW) + (ARW'(m2_lh_reg) << PW);
            m3_sb_reg      <= {m2_sb_hd_reg, m2_sb_reg};
        end
    end

    tm_sqrt_chain #(.LANES(1), .RW(ARW), .SBW(PW+2*CW+1)) u_area_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m3_v_reg),
        .in_ready (ac_in_rdy),
        .rad_in   (m3_prod_reg),
        .sb_in    (m3_sb_reg),
        .out_valid(ac_out_v),
        .out_ready(o_rdy),
        .root_out (ac_root),
        .sb_out   (ac_sb)
    );

    // ---------------- output register ----------------
    // The root carries 2*FRAC_BITS+2 fraction bits; the shift leaves FRAC_BITS.
    assign area_ext  = XW'(ac_root[0] >> (FRAC_BITS + 2));
    assign area_next = !ac_sb[PW+2*CW] ? '0 :
                       (area_ext > XW'(AREA_MAX)) ? AREA_MAX : area_ext[AREA_WIDTH-1:0];

    assign o_rdy = !o_v_reg || metrics.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (o_rdy)
            o_v_reg <= ac_out_v;
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy && ac_out_v)
        begin
            o_ok_reg   <= ac_sb[PW+2*CW];
            o_per_reg  <= ac_sb[PW+2*CW-1:2*CW];
            o_area_reg <= area_next;
            o_gx_reg   <= ac_sb[2*CW-1:CW];
            o_gy_reg   <= ac_sb[CW-1:0];
        end
    end

    assign metrics.valid       = o_v_reg;
    assign metrics.is_triangle = o_ok_reg;
    assign metrics.perimeter   = o_per_reg;
    assign metrics.area        = o_area_reg;
    assign metrics.centroid_x  = o_gx_reg;
    assign metrics.centroid_y  = o_gy_reg;
endmodule
`default_nettype wire

// File: sv/tm_checker.sv
// Port-level checker for the triangle metrics block and its bind statement.
`default_nettype none
module tm_checker #(
    parameter int CW = tm_pkg::COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          is_triangle,
    input logic [CW+2:0]                 perimeter,
    input logic [tm_pkg::AREA_WIDTH-1:0] area
);
    import tm_pkg::*;

    // A stalled result keeps its valid, its area and its perimeter.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(area) && $stable(perimeter))
        else $error("stalled result changed");

    // A degenerate triangle reports zero area.
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_triangle |-> area == '0)
        else $error("area reported for a non-triangle");

    // A zero perimeter can never satisfy the strict inequality.
    a_zero_perim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && perimeter == '0 |-> !is_triangle)
        else $error("zero perimeter flagged as triangle");
endmodule

bind triangle_metrics tm_checker #(.CW(COORD_WIDTH)) u_tm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (metrics.valid),
    .out_ready  (metrics.ready),
    .is_triangle(metrics.is_triangle),
    .perimeter  (metrics.perimeter),
    .area       (metrics.area)
);
`default_nettype wire

// File: bench/triangle_metrics_test.sv
// Self-checking test bench for the triangle metrics pipeline.
`default_nettype none
module triangle_metrics_test;

    localparam int CW = tm_pkg::COORD_WIDTH_DEF;
    localparam int FB = tm_pkg::FRAC_BITS_DEF;
    localparam int PW = CW + 3;
    localparam int AW = tm_pkg::AREA_WIDTH;
    // Settling wait after the last check, well above the pipeline depth at the default widths.
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic          is_triangle;
        logic [PW-1:0] perimeter;
        logic [AW-1:0] area;
        logic [CW-1:0] centroid_x;
        logic [CW-1:0] centroid_y;
    } metrics_t;

    logic clk;
    logic rst_n;

    tm_in_if  #(.CW(CW)) vertices ();
    tm_out_if #(.CW(CW)) metrics ();

    triangle_metrics DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vertices.sink),
        .metrics  (metrics.source)
    );

    // Expected metrics, oldest first; one entry is pushed per accepted triangle.
    metrics_t expected_metrics[$];
    int       mismatch_count;
    bit       sink_stalls_long;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Floor square root, built one result bit at a time.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= n)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [63:0] side_length(input longint x0, input longint y0,
                                                input longint x1, input longint y1);
        longint dx;
        longint dy;
        dx = x0 - x1;
        dy = y0 - y1;
        return floor_sqrt(128'(dx * dx) + 128'(dy * dy));
    endfunction

    // Computes the metrics that the block must return for one triangle.
    function automatic metrics_t triangle_metrics_of(
        input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
        input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
        input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
        metrics_t     m;
        logic [63:0]  sa;
        logic [63:0]  sb;
        logic [63:0]  sc;
        logic [63:0]  per;
        logic [127:0] prod;
        logic [63:0]  area;
        longint       gx;
        longint       gy;
        sa = side_length(ax, ay, bx, by);
        sb = side_length(bx, by, cx, cy);
        sc = side_length(cx, cy, ax, ay);
        per = sa + sb + sc;
        m.is_triangle = (sa + sb > sc) && (sb + sc > sa) && (sa + sc > sb);
        area = '0;
        if (m.is_triangle)
        begin
            prod = 128'(per * (sb + sc - sa)) * 128'((sa + sc - sb) * (sa + sb - sc));
            area = floor_sqrt(prod) >> (FB + 2);
        end
        m.perimeter = (per > {PW{1'b1}}) ? {PW{1'b1}} : per[PW-1:0];
        m.area      = (area > {AW{1'b1}}) ? {AW{1'b1}} : area[AW-1:0];
        // SystemVerilog integer division truncates toward zero, as required.
        gx = (longint'(ax) + longint'(bx) + longint'(cx)) / 3;
        gy = (longint'(ay) + longint'(by) + longint'(cy)) / 3;
        m.centroid_x = gx[CW-1:0];
        m.centroid_y = gy[CW-1:0];
        return m;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Sends one triangle transaction and records its expected metrics on acceptance.
    // Ready is sampled mid-cycle, where it is settled for the coming edge.
    task automatic send_triangle(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                 input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                 input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                                 input bit no_gap);
        int gap;
        bit accepted;
        gap = no_gap ? 0 : random_gap();
        if (gap > 0)
        begin
            vertices.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertices.valid    <= 1'b1;
        vertices.ax       <= ax;
        vertices.ay       <= ay;
        vertices.bx       <= bx;
        vertices.by_coord <= by;
        vertices.cx       <= cx;
        vertices.cy       <= cy;
        do
        begin
            @(negedge clk);
            accepted = vertices.ready;
            @(posedge clk);
        end
        while (!accepted);
        expected_metrics.push_back(triangle_metrics_of(ax, ay, bx, by, cx, cy));
    endtask

    task automatic send_random(input int count, input int span, input bit no_gap);
        logic signed [CW-1:0] c[6];
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (span >= 32768)
                    c[k] = CW'($urandom);
                else
                    c[k] = CW'($urandom_range(0, 2 * span) - span);
            end
            send_triangle(c[0], c[1], c[2], c[3], c[4], c[5], no_gap);
        end
    endtask

    // Directed cases: extreme coordinates, degenerate shapes and sign handling of the centroid.
    task automatic test_directed();
        send_triangle(0, 0, 0, 0, 0, 0, 0);
        send_triangle(0, 0, 16'sd256, 0, 0, 16'sd256, 0);
        send_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 0);
        send_triangle(32767, 32767, -32768, 32767, 32767, -32768, 0);
        send_triangle(-32768, 0, 32767, 0, 0, 32767, 0);
        send_triangle(-32768, -32768, -32768, -32768, -32768, -32768, 0);
        send_triangle(32767, 32767, 32767, 32767, 32767, 32767, 0);
        // Collinear points: the triangle inequality fails with equality.
        send_triangle(0, 0, 16'sd256, 0, 16'sd512, 0, 0);
        send_triangle(-100, -100, 0, 0, 100, 100, 0);
        // Two coincident vertices.
        send_triangle(10, 20, 10, 20, 300, -400, 0);
        // Very thin triangle whose rounded sides may still fail the inequality.
        send_triangle(0, 0, 1000, 1, 2000, 0, 0);
        send_triangle(0, 0, 1, 1, 2, 1, 0);
        // Negative sums, some of them not multiples of three, for truncation toward zero.
        send_triangle(-1, -2, 0, 0, 0, 0, 0);
        send_triangle(-4, 5, 0, -7, 0, 1, 0);
        send_triangle(-32768, -32768, -32768, -32768, 32767, 32767, 0);
        send_triangle(-1, -1, -1, -1, -1, -1, 0);
        send_triangle(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh00FF, 16'shFF00, 0);
        send_triangle(-32768, 32767, 0, 0, 32767, 32767, 0);
    endtask

    // Coordinates over the whole range, with gaps.
    task automatic test_full_range();
        send_random(900, 32768, 0);
    endtask

    // Small triangles, where rounding of the sides matters most.
    task automatic test_small_triangles();
        send_random(500, 64, 0);
    endtask

    // Back-to-back transactions, first while the sink stalls for long stretches, then with fewer stalls.
    task automatic test_back_pressure();
        sink_stalls_long = 1'b1;
        send_random(300, 32768, 1);
        sink_stalls_long = 1'b0;
        send_random(230, 2000, 1);
    endtask

    // Result sink: random stalls on ready, checking of every accepted transaction.
    // The handshake is sampled mid-cycle, where it is settled for the coming edge.
    initial
    begin
        metrics.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (metrics.valid && metrics.ready)
            begin
                metrics_t got;
                metrics_t exp;
                got.is_triangle = metrics.is_triangle;
                got.perimeter   = metrics.perimeter;
                got.area        = metrics.area;
                got.centroid_x  = metrics.centroid_x;
                got.centroid_y  = metrics.centroid_y;
                if (expected_metrics.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected metrics transaction: %p", got);
                end
                else
                begin
                    exp = expected_metrics.pop_front();
                    if (got !== exp)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Metrics mismatch: expected %p, actual %p", exp, got);
                    end
                end
            end
            @(posedge clk);
            // Stalls are drawn one cycle at a time; the long phase keeps ready low more often.
            if (sink_stalls_long)
                metrics.ready <= ($urandom_range(0, 99) < 35);
            else
                metrics.ready <= ($urandom_range(0, 99) < 80);
        end
    end

    // Generous time limit for the whole run.
    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int waited;
        mismatch_count    = 0;
        sink_stalls_long  = 1'b0;
        rst_n             = 1'b0;
        vertices.valid    <= 1'b0;
        vertices.ax       <= '0;
        vertices.ay       <= '0;
        vertices.bx       <= '0;
        vertices.by_coord <= '0;
        vertices.cx       <= '0;
        vertices.cy       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_range();
        test_small_triangles();
        test_back_pressure();
        vertices.valid <= 1'b0;

        // Wait for every expected transaction, then allow the pipeline to settle.
        waited = 0;
        while (expected_metrics.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_metrics.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
